[design/alkd_pkg.sv]
// ----------------------------------------------------------------------------
// alkd_pkg - shared types and constants for the ladder keypad debounce unit
// Configuration layout, item kinds, register indexes and inter-stage structs.
// ----------------------------------------------------------------------------
package alkd_pkg;

  localparam int UV_W   = 21;   // microvolt quantities
  localparam int RAW_W  = 12;   // converter result
  localparam int PROD_W = 33;   // raw * reference
  localparam int SS_W   = 4;    // stable sample count
  localparam int CODE_W = 16;   // scan code
  localparam int CLS_W  = 3;    // 0 none, 1..4 key index plus one
  localparam int ITEM_Q_DEPTH = 4;
  localparam int FIFO_AW      = 2;

  // item kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CLS_W-1:0] CLS_NONE = 3'd0;
  localparam logic [CLS_W-1:0] CLS_KEY0 = 3'd1;
  localparam logic [CLS_W-1:0] CLS_KEY1 = 3'd2;
  localparam logic [CLS_W-1:0] CLS_KEY2 = 3'd3;
  localparam logic [CLS_W-1:0] CLS_KEY3 = 3'd4;

  // register indexes
  localparam logic [2:0] REG_KEY0_TH   = 3'd0;
  localparam logic [2:0] REG_KEY1_TH   = 3'd1;
  localparam logic [2:0] REG_KEY2_TH   = 3'd2;
  localparam logic [2:0] REG_KEY3_TH   = 3'd3;
  localparam logic [2:0] REG_RELEASE   = 3'd4;
  localparam logic [2:0] REG_STABLE    = 3'd5;
  localparam logic [2:0] REG_SCAN_TAB  = 3'd6;
  localparam logic [2:0] REG_REFERENCE = 3'd7;

  // reset values
  localparam logic [UV_W-1:0] RST_KEY0_TH   = 21'd17000;
  localparam logic [UV_W-1:0] RST_KEY1_TH   = 21'd300000;
  localparam logic [UV_W-1:0] RST_KEY2_TH   = 21'd987000;
  localparam logic [UV_W-1:0] RST_KEY3_TH   = 21'd1310000;
  localparam logic [UV_W-1:0] RST_RELEASE   = 21'd1800000;
  localparam logic [SS_W-1:0] RST_STABLE    = 4'd3;
  localparam logic [63:0]     RST_SCAN_TAB  = 64'h0017_000D_0002_0001;
  localparam logic [UV_W-1:0] RST_REFERENCE = 21'd1800000;

  localparam logic [12:0] ADC_FULL_SCALE = 13'd4095;

  typedef struct packed {
    logic [UV_W-1:0] key0_threshold_uv;
    logic [UV_W-1:0] key1_threshold_uv;
    logic [UV_W-1:0] key2_threshold_uv;
    logic [UV_W-1:0] key3_threshold_uv;
    logic [UV_W-1:0] release_level_uv;
    logic [SS_W-1:0] stable_samples;
    logic [63:0]     scan_code_table;
    logic [UV_W-1:0] reference_uv;
  } alkd_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]       kind;
    logic             timed_out;
    logic [CLS_W-1:0] cls;
  } alkd_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } alkd_fifo_stat_t;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] scan_code;
    logic              key_down;
    logic [1:0]        events_queued;
    logic [2:0]        queue_count;
    logic [CLS_W-1:0]  candidate_key;
  } alkd_result_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_PUSH2,
    ST_READ
  } alkd_state_t;

endpackage

[design/alkd_front.sv]
// ----------------------------------------------------------------------------
// alkd_front - sample scaling and classification pipeline
// Four stages: multiply, two halves of the divide by 4095, threshold compare.
// ----------------------------------------------------------------------------
module alkd_front
  import alkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  alkd_cfg_t            cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [RAW_W-1:0]     in_raw,
  input  logic                 in_timed_out,
  output logic                 push,
  output alkd_item_t           push_item,
  input  logic                 fifo_full
);

  logic adv;

  logic              s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic [1:0]        s1_kind_r, s2_kind_r, s3_kind_r;
  logic              s1_to_r, s2_to_r, s3_to_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic [UV_W-1:0]   s2_q0_r;
  logic [UV_W:0]     s2_y1_r;
  logic [UV_W-1:0]   s3_uv_r;
  alkd_item_t        s4_item_r;

  logic [UV_W:0]     y1_nxt;
  logic [9:0]        q1;
  logic [12:0]       y2;
  logic              corr;
  logic [UV_W:0]     uv_sum;
  logic [CLS_W-1:0]  cls_nxt;

  // whole pipe moves together; holds only when the last stage cannot leave
  assign adv      = !s4_valid_r || !fifo_full;
  assign in_ready = adv;
  assign push     = s4_valid_r && adv;
  assign push_item = s4_item_r;

  // x = 4096*q0 + r0 = 4095*q0 + (q0 + r0), folded twice, then one correction
  assign y1_nxt = {1'b0, s1_prod_r[PROD_W-1:12]} + (UV_W+1)'(s1_prod_r[11:0]);
  assign q1     = s2_y1_r[UV_W:12];
  assign y2     = {1'b0, s2_y1_r[11:0]} + 13'(q1);
  assign corr   = (y2 >= ADC_FULL_SCALE);
  assign uv_sum = {1'b0, s2_q0_r} + (UV_W+1)'(q1) + (UV_W+1)'(corr);

  always_comb begin
    if (s3_uv_r >= cfg.release_level_uv) begin
      cls_nxt = CLS_NONE;
    end else if (s3_uv_r < cfg.key0_threshold_uv) begin
      cls_nxt = CLS_KEY0;
    end else if (s3_uv_r < cfg.key1_threshold_uv) begin
      cls_nxt = CLS_KEY1;
    end else if (s3_uv_r < cfg.key2_threshold_uv) begin
      cls_nxt = CLS_KEY2;
    end else if (s3_uv_r < cfg.key3_threshold_uv) begin
      cls_nxt = CLS_KEY3;
    end else begin
      cls_nxt = CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= in_kind;
      s1_to_r   <= in_timed_out;
      s1_prod_r <= PROD_W'(in_raw) * PROD_W'(cfg.reference_uv);
      s2_kind_r <= s1_kind_r;
      s2_to_r   <= s1_to_r;
      s2_q0_r   <= s1_prod_r[PROD_W-1:12];
      s2_y1_r   <= y1_nxt;
      s3_kind_r <= s2_kind_r;
      s3_to_r   <= s2_to_r;
      s3_uv_r   <= uv_sum[UV_W-1:0];
      s4_item_r.kind      <= s3_kind_r;
      s4_item_r.timed_out <= s3_to_r;
      s4_item_r.cls       <= cls_nxt;
    end
  end

endmodule

[design/alkd_fifo.sv]
// ----------------------------------------------------------------------------
// alkd_fifo - short item queue between front and back
// Registered slots, first word visible at the head.
// ----------------------------------------------------------------------------
module alkd_fifo
  import alkd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  alkd_item_t      push_item,
  input  logic            pop,
  output alkd_item_t      head_item,
  output alkd_fifo_stat_t stat
);

  alkd_item_t         slot_r [ITEM_Q_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign head_item  = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == (FIFO_AW+1)'(ITEM_Q_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

[design/alkd_back.sv]
// ----------------------------------------------------------------------------
// alkd_back - debounce counter, key event ring and result register
// Sequencer for the two pushes of a press and the registered ring read.
// ----------------------------------------------------------------------------
module alkd_back
  import alkd_pkg::*;
#(
  parameter int QUEUE_SLOTS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  alkd_cfg_t       cfg,
  input  alkd_item_t      item,
  input  alkd_fifo_stat_t fifo_stat,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output alkd_result_t    out_res
);

  localparam int PW = $clog2(QUEUE_SLOTS);
  localparam int FW = (PW > 3) ? PW : 3;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_fill(input logic [PW-1:0] h,
                                              input logic [PW-1:0] t);
    logic [PW:0] diff;
    diff = (t >= h) ? ({1'b0, t} - {1'b0, h})
                    : ({1'b0, t} + (PW+1)'(QUEUE_SLOTS) - {1'b0, h});
    ring_fill = diff[PW-1:0];
  endfunction

  logic [CODE_W:0]   ring_mem [QUEUE_SLOTS];
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [CODE_W:0]   mem_wdata;
  logic [CODE_W:0]   rd_q_r;

  alkd_state_t       state_r, state_nxt;
  logic [PW-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [CLS_W-1:0]  last_class_r, last_class_nxt;
  logic [SS_W-1:0]   stable_r, stable_nxt;
  logic [CODE_W-1:0] sc_r, sc_nxt;
  logic              q1_r, q1_nxt;
  logic              out_valid_r;
  alkd_result_t      out_res_r, res;
  logic              out_load, load_ok;

  logic [SS_W:0]     cap, inc, cnt;
  logic              fire, ring_full, push2;
  logic [1:0]        kidx;
  logic [CODE_W-1:0] sc_sel;
  logic [FW-1:0]     fill_ext;

  assign load_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign ring_full = (ptr_inc(tail_r) == head_r);

  // debounce arithmetic on the head item
  assign kidx   = 2'(item.cls - 3'd1);
  assign sc_sel = cfg.scan_code_table[{kidx, 4'd0} +: CODE_W];

  always_comb begin
    cap = {1'b0, cfg.stable_samples} + 5'd1;
    if (cap > 5'd15) cap = 5'd15;
    inc = {1'b0, stable_r} + 5'd1;
    if (item.cls == last_class_r) begin
      cnt  = (inc > cap) ? cap : inc;
      fire = (cnt == {1'b0, cfg.stable_samples}) && (stable_r < cfg.stable_samples);
    end else begin
      cnt  = 5'd1;
      fire = (cfg.stable_samples == 4'd1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    last_class_nxt = last_class_r;
    stable_nxt     = stable_r;
    sc_nxt         = sc_r;
    q1_nxt         = q1_r;
    pop            = 1'b0;
    out_load       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = tail_r;
    mem_wdata      = '0;
    push2          = 1'b0;
    res            = '0;
    case (state_r)
      ST_EXEC: begin
        if (!fifo_stat.empty && load_ok) begin
          pop = 1'b1;
          case (item.kind)
            KIND_SAMPLE: begin
              if (!item.timed_out) begin
                last_class_nxt = item.cls;
                stable_nxt     = cnt[SS_W-1:0];
                if (fire && item.cls != CLS_NONE) begin
                  sc_nxt    = sc_sel;
                  state_nxt = ST_PUSH2;
                  q1_nxt    = !ring_full;
                  if (!ring_full) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, sc_sel};
                    tail_nxt  = ptr_inc(tail_r);
                  end
                end else begin
                  out_load = 1'b1;
                end
              end else begin
                out_load = 1'b1;
              end
            end
            KIND_READ: begin
              if (head_r != tail_r) begin
                state_nxt = ST_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            KIND_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              out_load = 1'b1;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_PUSH2: begin
        if (load_ok) begin
          push2 = !ring_full;
          if (!ring_full) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, sc_r};
            tail_nxt  = ptr_inc(tail_r);
          end
          res.events_queued = {1'b0, q1_r} + {1'b0, push2};
          out_load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_READ: begin
        if (load_ok) begin
          res.key_valid = 1'b1;
          res.scan_code = rd_q_r[CODE_W-1:0];
          res.key_down  = rd_q_r[CODE_W];
          head_nxt      = ptr_inc(head_r);
          out_load      = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      default: state_nxt = ST_EXEC;
    endcase
    fill_ext          = FW'(ring_fill(head_nxt, tail_nxt));
    res.queue_count   = fill_ext[2:0];
    res.candidate_key = last_class_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_EXEC;
      head_r       <= '0;
      tail_r       <= '0;
      last_class_r <= CLS_NONE;
      stable_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      last_class_r <= last_class_nxt;
      stable_r     <= stable_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;
    q1_r <= q1_nxt;
    if (out_load) out_res_r <= res;
  end

  // event ring: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    rd_q_r <= ring_mem[head_r];
  end

endmodule

[design/adc_ladder_keypad_debounce_unit.sv]
// ----------------------------------------------------------------------------
// adc_ladder_keypad_debounce_unit - resistor-ladder keypad front end
// Scales ADC samples, debounces the key class and queues key events.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one item per handshake. tuser picks the kind (sample, read one
//           queued event, clear queue) and flags a timed-out conversion;
//           tdata carries the 12-bit raw sample.
//   out_* : exactly one result item per input item, in input order.
//           tuser says whether a read returned an event; tdata carries the
//           scan code, press/release bit, events queued, queue fill and the
//           current candidate key.
//   cfg_* : register writes, one per cycle; the user must issue them only while
//           the unit is idle, as the unit itself does not enforce this.
// Throughput: one item per cycle while nothing stalls; a confirming sample
// also holds the back end in ST_PUSH2 (two pushes through the single ring
// write port), a returning read in ST_READ (registered ring read). A 4-entry
// queue between classify pipeline and back end lets each side stall alone.
// Reset (synchronous, rst_n low) restores register defaults, empties the
// event ring and clears the debounce state; no clearing pass is needed.
// When out_tready is low the result register holds; in_tready drops while
// the internal queue is full and an item waits at the end of the pipeline.
// ----------------------------------------------------------------------------
module adc_ladder_keypad_debounce_unit
  import alkd_pkg::*;
#(
  parameter int QUEUE_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_sample, rest zero
  input  logic [2:0]  in_tuser,   // [1:0] kind, [2] sample_timed_out
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] scan_code, [16] key_down,
                                  // [18:17] events_queued, [21:19] queue_count,
                                  // [24:22] candidate_key, rest zero
  output logic [0:0]  out_tuser,  // [0] key_valid
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  alkd_cfg_t       cfg_r;
  logic            fifo_push, fifo_pop;
  alkd_item_t      fifo_in, fifo_head;
  alkd_fifo_stat_t fifo_stat;
  alkd_result_t    out_res;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key0_threshold_uv <= RST_KEY0_TH;
      cfg_r.key1_threshold_uv <= RST_KEY1_TH;
      cfg_r.key2_threshold_uv <= RST_KEY2_TH;
      cfg_r.key3_threshold_uv <= RST_KEY3_TH;
      cfg_r.release_level_uv  <= RST_RELEASE;
      cfg_r.stable_samples    <= RST_STABLE;
      cfg_r.scan_code_table   <= RST_SCAN_TAB;
      cfg_r.reference_uv      <= RST_REFERENCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0_TH:   cfg_r.key0_threshold_uv <= cfg_wdata[UV_W-1:0];
        REG_KEY1_TH:   cfg_r.key1_threshold_uv <= cfg_wdata[UV_W-1:0];
        REG_KEY2_TH:   cfg_r.key2_threshold_uv <= cfg_wdata[UV_W-1:0];
        REG_KEY3_TH:   cfg_r.key3_threshold_uv <= cfg_wdata[UV_W-1:0];
        REG_RELEASE:   cfg_r.release_level_uv  <= cfg_wdata[UV_W-1:0];
        REG_STABLE:    cfg_r.stable_samples    <= cfg_wdata[SS_W-1:0];
        REG_SCAN_TAB:  cfg_r.scan_code_table   <= cfg_wdata;
        REG_REFERENCE: cfg_r.reference_uv      <= cfg_wdata[UV_W-1:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  // front: scale and classify
  alkd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_kind      (in_tuser[1:0]),
    .in_raw       (in_tdata[RAW_W-1:0]),
    .in_timed_out (in_tuser[2]),
    .push         (fifo_push),
    .push_item    (fifo_in),
    .fifo_full    (fifo_stat.full)
  );

  alkd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_item (fifo_in),
    .pop       (fifo_pop),
    .head_item (fifo_head),
    .stat      (fifo_stat)
  );

  // back: debounce, event ring, result register
  alkd_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item      (fifo_head),
    .fifo_stat (fifo_stat),
    .pop       (fifo_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'd0, out_res.candidate_key, out_res.queue_count,
                      out_res.events_queued, out_res.key_down, out_res.scan_code};
  assign out_tuser = out_res.key_valid;

  // checks
  a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_stat.full)
    else $error("front pushed into a full item queue");

  a_no_fifo_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_stat.empty)
    else $error("back popped an empty item queue");

  a_read_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.key_valid |-> out_res.events_queued == 2'd0)
    else $error("returned event also reports queued events");

  a_candidate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_res.candidate_key <= CLS_KEY3)
    else $error("candidate key out of range");

endmodule

[tb/sv/tb_adc_ladder_keypad_debounce_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_ladder_keypad_debounce_unit - self-checking bench for the keypad unit
// Walks a short directed table from reset, then several register settings
// with random sample runs, reads and clears. Results are compared field by
// field with a model of ladder, debounce and ring, or a typed row's own value.
// ----------------------------------------------------------------------------
module tb_adc_ladder_keypad_debounce_unit
  import alkd_pkg::*;
();

  localparam int SLOTS       = 8;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 140;
  // kind 3 is not decoded by the unit; the item only reports fill and class
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam alkd_result_t NO_RESULT = '0;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [1:0]       kind;
    logic [RAW_W-1:0] raw;
    logic             timed_out;
    logic             typed;
    alkd_result_t     res;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata  = '0;   // [11:0] adc_sample
  logic [2:0]  in_tuser  = '0;   // [1:0] kind, [2] sample_timed_out
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [15:0] scan_code, [16] key_down,
                                 // [18:17] events_queued, [21:19] queue_count,
                                 // [24:22] candidate_key
  logic [0:0]  out_tuser;        // [0] key_valid
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  // no idling on either side while set
  bit calm   = 1'b0;
  int errors = 0;

  // local copy of the unit: registers, event ring and debounce state
  alkd_cfg_t        kp_cfg;
  logic [16:0]      ring [SLOTS];
  int unsigned      ring_head, ring_tail;
  logic [CLS_W-1:0] held_class;
  int unsigned      held_count;
  alkd_result_t     expected_q [$];
  stim_row_t        dir_rows [$];

  adc_ladder_keypad_debounce_unit #(
    .QUEUE_SLOTS (SLOTS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // model of the unit
  // --------------------------------------------------------------------------
  task automatic model_reset();
    kp_cfg.key0_threshold_uv = RST_KEY0_TH;
    kp_cfg.key1_threshold_uv = RST_KEY1_TH;
    kp_cfg.key2_threshold_uv = RST_KEY2_TH;
    kp_cfg.key3_threshold_uv = RST_KEY3_TH;
    kp_cfg.release_level_uv  = RST_RELEASE;
    kp_cfg.stable_samples    = RST_STABLE;
    kp_cfg.scan_code_table   = RST_SCAN_TAB;
    kp_cfg.reference_uv      = RST_REFERENCE;
    for (int i = 0; i < SLOTS; i++) ring[i] = '0;
    ring_head  = 0;
    ring_tail  = 0;
    held_class = CLS_NONE;
    held_count = 0;
  endtask

  // scale to microvolts (truncating) and pick the first threshold beaten
  function automatic logic [CLS_W-1:0] ladder_class(input logic [RAW_W-1:0] raw);
    logic [PROD_W-1:0] uv;
    uv = (PROD_W'(raw) * PROD_W'(kp_cfg.reference_uv)) / PROD_W'(4095);
    if (uv >= PROD_W'(kp_cfg.release_level_uv))  return CLS_NONE;
    if (uv <  PROD_W'(kp_cfg.key0_threshold_uv)) return CLS_KEY0;
    if (uv <  PROD_W'(kp_cfg.key1_threshold_uv)) return CLS_KEY1;
    if (uv <  PROD_W'(kp_cfg.key2_threshold_uv)) return CLS_KEY2;
    if (uv <  PROD_W'(kp_cfg.key3_threshold_uv)) return CLS_KEY3;
    return CLS_NONE;
  endfunction

  function automatic int unsigned ring_fill();
    return (ring_tail + SLOTS - ring_head) % SLOTS;
  endfunction

  // one slot always stays free; a push onto a full ring is lost
  function automatic int unsigned ring_push(input logic [CODE_W-1:0] code,
                                            input logic down);
    int unsigned nxt;
    nxt = (ring_tail + 1) % SLOTS;
    if (nxt == ring_head) return 0;
    ring[ring_tail] = {down, code};
    ring_tail = nxt;
    return 1;
  endfunction

  function automatic alkd_result_t keypad_step(input logic [1:0] kind,
                                               input logic [RAW_W-1:0] raw,
                                               input logic timed_out);
    alkd_result_t     r;
    logic [CLS_W-1:0] cls;
    int unsigned      cap, nxt, nq, stable, slot;
    bit               fire;
    logic [CODE_W-1:0] sc;
    r      = '0;
    nq     = 0;
    stable = kp_cfg.stable_samples;
    if (kind == KIND_SAMPLE && !timed_out) begin
      cls = ladder_class(raw);
      cap = stable + 1;
      if (cap > 15) cap = 15;
      if (cls == held_class) begin
        nxt = held_count + 1;
        if (nxt > cap) nxt = cap;
        // fires once when the run first reaches the limit, never again
        fire = (nxt == stable) && (held_count < stable);
      end else begin
        nxt  = 1;
        fire = (stable == 1);
      end
      held_class = cls;
      held_count = nxt;
      if (fire && cls != CLS_NONE) begin
        slot = cls - 1;
        sc   = kp_cfg.scan_code_table[slot*16 +: 16];
        nq   = ring_push(sc, 1'b1);
        nq  += ring_push(sc, 1'b0);
      end
      r.events_queued = 2'(nq);
    end else if (kind == KIND_READ) begin
      if (ring_head != ring_tail) begin
        r.key_valid = 1'b1;
        r.scan_code = ring[ring_head][15:0];
        r.key_down  = ring[ring_head][16];
        ring_head   = (ring_head + 1) % SLOTS;
      end
    end else if (kind == KIND_CLEAR) begin
      ring_head = 0;
      ring_tail = 0;
    end
    r.queue_count   = 3'(ring_fill());
    r.candidate_key = held_class;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // drivers: inputs change on the falling edge, handshakes seen on the rising
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] kind, input logic [RAW_W-1:0] raw,
                           input logic timed_out, input logic typed,
                           input alkd_result_t typed_res);
    int gap;
    alkd_result_t predicted;
    gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, raw};
    in_tuser  <= {timed_out, kind};
    do @(posedge clk); while (!in_tready);
    // item taken: advance the model even where the result is typed in
    predicted = keypad_step(kind, raw, timed_out);
    expected_q.push_back(typed ? typed_res : predicted);
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // all eight registers in back-to-back cycles; only called while idle
  task automatic write_regs(input alkd_cfg_t c);
    logic [63:0] v;
    logic [2:0]  idx;
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      case (idx)
        REG_KEY0_TH:   v = 64'(c.key0_threshold_uv);
        REG_KEY1_TH:   v = 64'(c.key1_threshold_uv);
        REG_KEY2_TH:   v = 64'(c.key2_threshold_uv);
        REG_KEY3_TH:   v = 64'(c.key3_threshold_uv);
        REG_RELEASE:   v = 64'(c.release_level_uv);
        REG_STABLE:    v = 64'(c.stable_samples);
        REG_SCAN_TAB:  v = c.scan_code_table;
        REG_REFERENCE: v = 64'(c.reference_uv);
        default:       v = '0;
      endcase
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= v;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    kp_cfg = c;
  endtask

  // receiver stalls on about 30 percent of cycles outside the calm stretch
  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    alkd_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.key_valid     = out_tuser[0];
      got.scan_code     = out_tdata[15:0];
      got.key_down      = out_tdata[16];
      got.events_queued = out_tdata[18:17];
      got.queue_count   = out_tdata[21:19];
      got.candidate_key = out_tdata[24:22];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("key_valid",     want.key_valid,     got.key_valid);
        check_field("scan_code",     want.scan_code,     got.scan_code);
        check_field("key_down",      want.key_down,      got.key_down);
        check_field("events_queued", want.events_queued, got.events_queued);
        check_field("queue_count",   want.queue_count,   got.queue_count);
        check_field("candidate_key", want.candidate_key, got.candidate_key);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    alkd_cfg_t        c;
    int               sent, run_len, r;
    int unsigned      refv, t0, t1, t2, t3, rel;
    logic [RAW_W-1:0] raw;
    bit               paused;

    model_reset();

    // directed table at reset settings (1.8 V reference): raw 0 is key0,
    // 500 key1, 1000 key2, 2500 key3, 3500 between key3 and release,
    // 4095 at the release level
    dir_rows.push_back('{KIND_READ,    12'd0,    1'b0, 1'b1, NO_RESULT}); // read, empty
    dir_rows.push_back('{KIND_UNUSED,  12'd4095, 1'b1, 1'b1, NO_RESULT}); // ignored kind
    dir_rows.push_back('{KIND_CLEAR,   12'd0,    1'b0, 1'b1, NO_RESULT}); // clear, empty
    dir_rows.push_back('{KIND_SAMPLE,  12'd4095, 1'b1, 1'b1, NO_RESULT}); // timed out
    dir_rows.push_back('{KIND_SAMPLE,  12'd0,    1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd0,    1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd0,    1'b0, 1'b0, NO_RESULT}); // key0 fires
    dir_rows.push_back('{KIND_SAMPLE,  12'd0,    1'b0, 1'b0, NO_RESULT}); // no repeat
    dir_rows.push_back('{KIND_SAMPLE,  12'd4095, 1'b0, 1'b0, NO_RESULT}); // released
    dir_rows.push_back('{KIND_SAMPLE,  12'd500,  1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd0,    1'b1, 1'b0, NO_RESULT}); // glitch ignored
    dir_rows.push_back('{KIND_SAMPLE,  12'd500,  1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd500,  1'b0, 1'b0, NO_RESULT}); // key1 fires
    dir_rows.push_back('{KIND_SAMPLE,  12'd1000, 1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd1000, 1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd1000, 1'b0, 1'b0, NO_RESULT}); // key2 fires
    dir_rows.push_back('{KIND_SAMPLE,  12'd2500, 1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd2500, 1'b0, 1'b0, NO_RESULT});
    dir_rows.push_back('{KIND_SAMPLE,  12'd2500, 1'b0, 1'b0, NO_RESULT}); // ring full, drop
    dir_rows.push_back('{KIND_SAMPLE,  12'd3500, 1'b0, 1'b0, NO_RESULT}); // above key3
    dir_rows.push_back('{KIND_READ,    12'd0,    1'b0, 1'b1,
                         '{1'b1, 16'h0001, 1'b1, 2'd0, 3'd6, CLS_NONE}}); // key0 press
    dir_rows.push_back('{KIND_READ,    12'd0,    1'b0, 1'b0, NO_RESULT}); // key0 release
    dir_rows.push_back('{KIND_CLEAR,   12'd0,    1'b0, 1'b1, NO_RESULT});
    dir_rows.push_back('{KIND_READ,    12'd0,    1'b0, 1'b1, NO_RESULT}); // empty again

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].raw, dir_rows[i].timed_out,
                dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 1; ph <= PHASES; ph++) begin
      settle();
      c = kp_cfg;
      case (ph)
        1: begin
          // reset ladder, single-sample debounce, no idling at all
          c.stable_samples  = 4'd1;
          c.scan_code_table = {$urandom, $urandom};
        end
        3: begin
          // zero reference: every sample reads 0 uV, always key0
          c.reference_uv      = '0;
          c.key0_threshold_uv = '1;
          c.key1_threshold_uv = '1;
          c.key2_threshold_uv = '1;
          c.key3_threshold_uv = '1;
          c.release_level_uv  = '1;
          c.stable_samples    = 4'd2;
          c.scan_code_table   = {$urandom, $urandom};
        end
        4: begin
          // zero release level: nothing ever classifies as a key
          c.reference_uv      = '1;
          c.key0_threshold_uv = '0;
          c.key1_threshold_uv = '0;
          c.key2_threshold_uv = '0;
          c.key3_threshold_uv = '0;
          c.release_level_uv  = '0;
          c.stable_samples    = 4'($urandom_range(1, 14));
          c.scan_code_table   = {$urandom, $urandom};
        end
        5: begin
          // anything goes, thresholds in no particular order
          c.reference_uv      = 21'($urandom);
          c.key0_threshold_uv = 21'($urandom);
          c.key1_threshold_uv = 21'($urandom);
          c.key2_threshold_uv = 21'($urandom);
          c.key3_threshold_uv = 21'($urandom);
          c.release_level_uv  = 21'($urandom);
          c.stable_samples    = 4'($urandom_range(1, 14));
          c.scan_code_table   = {$urandom, $urandom};
        end
        default: begin
          // ascending ladder spread over the reference, full scale in phase 2
          refv = (ph == 2) ? 32'h1F_FFFF : $urandom_range(1000, 2097151);
          t0   = $urandom_range(0, refv / 8);
          t1   = t0 + $urandom_range(0, refv / 4);
          t2   = t1 + $urandom_range(0, refv / 4);
          t3   = t2 + $urandom_range(0, refv / 4);
          rel  = t3 + $urandom_range(0, refv / 4);
          c.reference_uv      = 21'(refv);
          c.key0_threshold_uv = 21'(t0);
          c.key1_threshold_uv = 21'(t1);
          c.key2_threshold_uv = 21'(t2);
          c.key3_threshold_uv = 21'(t3);
          c.release_level_uv  = 21'(rel);
          c.stable_samples    = (ph == 2) ? 4'd14 : 4'($urandom_range(1, 14));
          c.scan_code_table   = {$urandom, $urandom};
        end
      endcase
      write_regs(c);
      calm   = (ph == 1);
      sent   = 0;
      paused = 1'b0;

      while (sent < PHASE_ITEMS) begin
        // once, hold the sender until the unit has answered everything
        if (ph == 5 && !paused && sent >= 60) begin
          settle();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 55) begin
          // a run of one reading, long enough to pass the debounce mostly
          if ($urandom_range(99) < 10)
            raw = $urandom_range(1) ? '1 : '0;
          else
            raw = 12'($urandom_range(0, 4095));
          run_len = $urandom_range(1, int'(kp_cfg.stable_samples) + 3);
          for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(99) < 8)
              send_item(KIND_SAMPLE, 12'($urandom), 1'b1, 1'b0, NO_RESULT);
            else if ($urandom_range(99) < 10)
              send_item(KIND_SAMPLE, raw ^ 12'($urandom_range(1, 7)), 1'b0,
                        1'b0, NO_RESULT);
            else
              send_item(KIND_SAMPLE, raw, 1'b0, 1'b0, NO_RESULT);
            sent++;
          end
        end else if (r < 82) begin
          send_item(KIND_READ, 12'($urandom), 1'b0, 1'b0, NO_RESULT);
          sent++;
        end else if (r < 86) begin
          send_item(KIND_CLEAR, 12'($urandom), 1'($urandom), 1'b0, NO_RESULT);
          sent++;
        end else if (r < 93) begin
          send_item(KIND_SAMPLE, 12'($urandom), 1'($urandom), 1'b0, NO_RESULT);
          sent++;
        end else begin
          send_item(KIND_UNUSED, 12'($urandom), 1'($urandom), 1'b0, NO_RESULT);
          sent++;
        end
      end
    end

    calm = 1'b0;
    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // a correct run finishes long before this limit
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[adc_ladder_keypad_debounce_unit.f]
design/alkd_pkg.sv
design/alkd_front.sv
design/alkd_fifo.sv
design/alkd_back.sv
design/adc_ladder_keypad_debounce_unit.sv
tb/sv/tb_adc_ladder_keypad_debounce_unit.sv
